@@ hw/rtl/clcd_pkg.sv @@
package clcd_pkg;

   // Saturation limits for the lines_in_use and chars_per_line registers.
   localparam logic [2:0] MAX_LINES   = 3'd4;
   localparam logic [5:0] MAX_COLUMNS = 6'd40;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Request opcodes.
   localparam logic [1:0] OP_SHOW_CHAR   = 2'd0;
   localparam logic [1:0] OP_GO_TO_LINE  = 2'd1;
   localparam logic [1:0] OP_RAW_COMMAND = 2'd2;
   localparam logic [1:0] OP_CLEAR       = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] REG_EIGHT_BIT_BUS  = 3'd0;
   localparam logic [2:0] REG_LINES_IN_USE   = 3'd1;
   localparam logic [2:0] REG_CHARS_PER_LINE = 3'd2;
   localparam logic [2:0] REG_LINE0_ADDRESS  = 3'd3;
   localparam logic [2:0] REG_LINE1_ADDRESS  = 3'd4;
   localparam logic [2:0] REG_LINE2_ADDRESS  = 3'd5;
   localparam logic [2:0] REG_LINE3_ADDRESS  = 3'd6;

   // Register select values on the panel bus.
   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   typedef struct packed {
      logic [2:0]      lines_in_use;
      logic [5:0]      chars_per_line;
      logic [3:0][7:0] line_address;
   } cfg_type;

   // One or two bytes that a request sends, in order.
   typedef struct packed {
      logic       two_bytes;
      logic       rs0;
      logic [7:0] byte0;
      logic       rs1;
      logic [7:0] byte1;
   } job_type;

endpackage

@@ hw/rtl/clcd_req_if.sv @@
interface clcd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] char_code;
   logic [2:0] line_number;
   logic [7:0] command_byte;

   modport source (output valid, output opcode, output char_code, output line_number,
                   output command_byte, input ready);
   modport sink (input valid, input opcode, input char_code, input line_number,
                 input command_byte, output ready);
endinterface

@@ hw/rtl/clcd_rsp_if.sv @@
interface clcd_rsp_if;
   logic       valid;
   logic       ready;
   logic       register_select;
   logic [7:0] bus_byte;
   logic       last_transfer;

   modport source (output valid, output register_select, output bus_byte,
                   output last_transfer, input ready);
   modport sink (input valid, input register_select, input bus_byte,
                 input last_transfer, output ready);
endinterface

@@ hw/rtl/char_lcd_write_controller.sv @@
// Character LCD write controller: requests in, panel bus beats out.
// An emitted request is queued, then loaded into the back-end work registers.
// Throughput: one bus beat per cycle while rsp.ready is high. An emitted request
// gives 1 to 2 beats in 8-bit mode and 2 to 4 in nibble mode.
// A four-entry queue lets requests be accepted while earlier beats drain.
// Synchronous reset clears the cursor, the queue and loads register defaults.
module char_lcd_write_controller
   import clcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   clcd_req_if.sink   req,
   clcd_rsp_if.source rsp,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_write_data
);

   logic    eight_bit_bus_ff;
   cfg_type cfg_ff;
   logic    queue_full;
   logic    push;
   job_type push_job;
   logic    pop_valid;
   logic    pop;
   job_type pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         eight_bit_bus_ff       <= 1'b1;
         cfg_ff.lines_in_use    <= 3'd2;
         cfg_ff.chars_per_line  <= 6'd16;
         cfg_ff.line_address[0] <= 8'h80;
         cfg_ff.line_address[1] <= 8'hC0;
         cfg_ff.line_address[2] <= 8'h90;
         cfg_ff.line_address[3] <= 8'hD0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_EIGHT_BIT_BUS:  eight_bit_bus_ff       <= csr_write_data[0];
            REG_LINES_IN_USE:   cfg_ff.lines_in_use    <= csr_write_data[2:0];
            REG_CHARS_PER_LINE: cfg_ff.chars_per_line  <= csr_write_data[5:0];
            REG_LINE0_ADDRESS:  cfg_ff.line_address[0] <= csr_write_data;
            REG_LINE1_ADDRESS:  cfg_ff.line_address[1] <= csr_write_data;
            REG_LINE2_ADDRESS:  cfg_ff.line_address[2] <= csr_write_data;
            REG_LINE3_ADDRESS:  cfg_ff.line_address[3] <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   clcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   clcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_job   (pop_job)
   );

   clcd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .eight_bit_bus (eight_bit_bus_ff),
      .job_valid     (pop_valid),
      .job           (pop_job),
      .pop           (pop),
      .rsp           (rsp)
   );

endmodule

@@ hw/rtl/clcd_front.sv @@
module clcd_front
   import clcd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   clcd_req_if.sink      req,
   input  logic          queue_full,
   output logic          push,
   output job_type       push_job
);

   logic [1:0] line_ff, line_in;
   logic [5:0] column_ff, column_in;
   logic [2:0] eff_lines;
   logic [5:0] eff_chars;
   logic [2:0] line_inc;
   logic [1:0] wrap_line;
   logic       is_newline;
   logic       wrap;
   logic       emit;
   logic       accept;
   job_type    job;

   assign eff_lines = (cfg.lines_in_use > MAX_LINES) ? MAX_LINES : cfg.lines_in_use;
   assign eff_chars = (cfg.chars_per_line > MAX_COLUMNS) ? MAX_COLUMNS : cfg.chars_per_line;

   // A wrap past the last line in use lands on line 0.
   assign line_inc  = {1'b0, line_ff} + 3'd1;
   assign wrap_line = (line_inc >= eff_lines) ? 2'd0 : line_inc[1:0];

   assign is_newline = (req.char_code == NEWLINE_CODE);
   assign wrap       = (column_ff >= eff_chars) || is_newline;

   always_comb begin
      job       = '0;
      emit      = 1'b0;
      line_in   = line_ff;
      column_in = column_ff;
      unique case (req.opcode)
         OP_SHOW_CHAR: begin
            emit = 1'b1;
            if (wrap) begin
               job.rs0   = RS_COMMAND;
               job.byte0 = cfg.line_address[wrap_line];
               line_in   = wrap_line;
               column_in = 6'd0;
            end
            if (!is_newline) begin
               column_in = (wrap ? 6'd0 : column_ff) + 6'd1;
               if (wrap) begin
                  job.two_bytes = 1'b1;
                  job.rs1       = RS_DATA;
                  job.byte1     = req.char_code;
               end else begin
                  job.rs0   = RS_DATA;
                  job.byte0 = req.char_code;
               end
            end
         end
         OP_GO_TO_LINE: begin
            if (req.line_number < eff_lines) begin
               emit      = 1'b1;
               job.rs0   = RS_COMMAND;
               job.byte0 = cfg.line_address[req.line_number[1:0]];
               line_in   = req.line_number[1:0];
               column_in = 6'd0;
            end
         end
         OP_RAW_COMMAND: begin
            emit      = 1'b1;
            job.rs0   = RS_COMMAND;
            job.byte0 = req.command_byte;
         end
         OP_CLEAR: begin
            emit      = 1'b1;
            job.rs0   = RS_COMMAND;
            job.byte0 = req.command_byte;
            if (eff_lines != 3'd0) begin
               job.two_bytes = 1'b1;
               job.rs1       = RS_COMMAND;
               job.byte1     = cfg.line_address[0];
               line_in       = 2'd0;
               column_in     = 6'd0;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign push      = accept && emit;
   assign push_job  = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff   <= 2'd0;
         column_ff <= 6'd0;
      end else if (accept) begin
         line_ff   <= line_in;
         column_ff <= column_in;
      end
   end

endmodule

@@ hw/rtl/clcd_queue.sv @@
module clcd_queue
   import clcd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   output logic    pop_valid,
   input  logic    pop,
   output job_type pop_job
);

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff;
   logic                do_push, do_pop;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + (QUEUE_AW+1)'(1);
            2'b01:   count_ff <= count_ff - (QUEUE_AW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

@@ hw/rtl/clcd_back.sv @@
module clcd_back
   import clcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       eight_bit_bus,
   input  logic       job_valid,
   input  job_type    job,
   output logic       pop,
   clcd_rsp_if.source rsp
);

   logic       work_valid_ff, work_valid_in;
   job_type    job_ff;
   logic [1:0] beat_ff, last_beat_ff;
   logic       done;
   logic       byte_sel;
   logic [7:0] cur_byte;

   // The work registers are free once the last beat of the held job is taken.
   assign done = !work_valid_ff || (rsp.ready && (beat_ff == last_beat_ff));
   assign pop  = done && job_valid;
   assign work_valid_in = done ? job_valid : work_valid_ff;

   // In nibble mode each byte takes two beats, high nibble first.
   assign byte_sel = eight_bit_bus ? beat_ff[0] : beat_ff[1];
   assign cur_byte = byte_sel ? job_ff.byte1 : job_ff.byte0;

   assign rsp.valid           = work_valid_ff;
   assign rsp.register_select = byte_sel ? job_ff.rs1 : job_ff.rs0;
   assign rsp.bus_byte        = eight_bit_bus ? cur_byte
                              : (beat_ff[0] ? {cur_byte[3:0], 4'h0} : {cur_byte[7:4], 4'h0});
   assign rsp.last_transfer   = (beat_ff == last_beat_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff       <= job;
         beat_ff      <= 2'd0;
         last_beat_ff <= eight_bit_bus ? {1'b0, job.two_bytes} : {job.two_bytes, 1'b1};
      end else if (work_valid_ff && rsp.ready) begin
         beat_ff <= beat_ff + 2'd1;
      end
   end

endmodule
